### design/rmsn_pkg.sv
// ----------------------------------------------------------------------------
// rmsn_pkg
// shared constants and control types of the rms normalizer
// ----------------------------------------------------------------------------
package rmsn_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int VAL_W       = 16;
    localparam int SUM_W       = 37;
    localparam int SQ_W        = 32;
    localparam int EPS_W       = 24;
    localparam logic [EPS_W-1:0] EPS_RESET = 24'd168;

    localparam int UNIT_W      = 62;
    localparam int OPND_W      = 61;
    localparam int DVSR_W      = 31;
    localparam int SCALE_W     = 31;
    localparam int STEP_W      = 6;

    localparam logic [STEP_W-1:0] MEAN_STEPS  = 6'd37;
    localparam logic [STEP_W-1:0] RECIP_STEPS = 6'd61;
    localparam logic [STEP_W-1:0] SQRT_STEPS  = 6'd31;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 31'h4000_0000;

    localparam logic [2:0] ADDR_EPSILON = 3'd0;

    typedef struct packed {
        logic              start;
        logic              is_sqrt;
        logic [STEP_W-1:0] steps;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

### design/rmsn_mem.sv
// ----------------------------------------------------------------------------
// rmsn_mem
// element and weight store, one write port and one registered read port
// ----------------------------------------------------------------------------
module rmsn_mem #(
    parameter int DEPTH = rmsn_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [2*rmsn_pkg::VAL_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [2*rmsn_pkg::VAL_W-1:0] rd_data
);

    logic [2*rmsn_pkg::VAL_W-1:0] mem [DEPTH];
    logic [2*rmsn_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/rmsn_unit.sv
// ----------------------------------------------------------------------------
// rmsn_unit
// shared shift-subtract unit: restoring division or digit-recurrence sqrt
// ----------------------------------------------------------------------------
module rmsn_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rmsn_pkg::unit_ctrl_t          ctrl,
    input  logic [rmsn_pkg::OPND_W-1:0]   operand,
    input  logic [rmsn_pkg::DVSR_W-1:0]   divisor,
    output rmsn_pkg::unit_stat_t          stat,
    output logic [rmsn_pkg::OPND_W-1:0]   result
);

    localparam int W = rmsn_pkg::UNIT_W;

    logic [W-1:0]                    a_reg, a_next;
    logic [W-1:0]                    b_reg, b_next;
    logic [W-1:0]                    bit_reg, bit_next;
    logic [rmsn_pkg::DVSR_W-1:0]     d_reg;
    logic                            sqrt_reg;
    logic [rmsn_pkg::STEP_W-1:0]     cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [W-1:0] r_sh;
    logic [W-1:0] lhs;
    logic [W-1:0] rhs;
    logic [W:0]   diff;
    logic         ge;

    always_comb
    begin
        r_sh = {a_reg[W-2:0], b_reg[rmsn_pkg::OPND_W-1]};
        lhs  = sqrt_reg ? a_reg : r_sh;
        rhs  = sqrt_reg ? (b_reg + bit_reg) : W'(d_reg);
        diff = {1'b0, lhs} - {1'b0, rhs};
        ge   = ~diff[W];
        if (sqrt_reg)
        begin
            a_next   = ge ? diff[W-1:0] : a_reg;
            b_next   = ge ? ((b_reg >> 1) + bit_reg) : (b_reg >> 1);
            bit_next = bit_reg >> 2;
        end
        else
        begin
            a_next   = ge ? diff[W-1:0] : r_sh;
            b_next   = {1'b0, b_reg[rmsn_pkg::OPND_W-2:0], ge};
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sqrt_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.steps;
                sqrt_reg <= ctrl.is_sqrt;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg   <= ctrl.is_sqrt ? W'(operand) : '0;
            b_reg   <= ctrl.is_sqrt ? '0 : W'(operand);
            bit_reg <= W'(1) << (2 * (rmsn_pkg::SQRT_STEPS - 1));
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            bit_reg <= bit_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = b_reg[rmsn_pkg::OPND_W-1:0];

endmodule

### design/rms_normalizer_top.sv
// ----------------------------------------------------------------------------
// rms_normalizer_top
// rms normalization of one vector per last-marked item, fixed point
// ----------------------------------------------------------------------------
// each input item is stored and squared, then accumulated before the next is taken
// the last item then runs the shared shift-subtract unit for the mean division,
// then the reciprocal division and square root unless mean plus epsilon is zero
// each result item then passes memory read, two multiplies, rounding and output
// reset is asynchronous active low; epsilon returns to 168, vector state clears
module rms_normalizer_top #(
    parameter int MAX_LEN = rmsn_pkg::MAX_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] element_value,
    input  logic signed [15:0] gain_weight,
    input  logic        end_of_vector,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] normalized_value,
    output logic        final_output,
    output logic        length_overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int VW = rmsn_pkg::VAL_W;
    localparam logic ADDR_EPSILON_BIT = rmsn_pkg::ADDR_EPSILON[2];

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_ACC    = 13'b0000000000010,
        S_MEAN   = 13'b0000000000100,
        S_MEANW  = 13'b0000000001000,
        S_RECIP  = 13'b0000000010000,
        S_RECIPW = 13'b0000000100000,
        S_SQRT   = 13'b0000001000000,
        S_SQRTW  = 13'b0000010000000,
        S_RD     = 13'b0000100000000,
        S_MUL1   = 13'b0001000000000,
        S_MUL2   = 13'b0010000000000,
        S_RND    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [rmsn_pkg::EPS_W-1:0]      eps_reg;
    logic [CW-1:0]                   count_reg, count_next;
    logic [rmsn_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic                            ovf_reg, ovf_next;
    logic                            last_reg;
    logic [rmsn_pkg::SQ_W-1:0]       sq_reg;
    logic [CW-1:0]                   k_reg, k_next;
    logic [rmsn_pkg::DVSR_W-1:0]     v_reg;
    logic [rmsn_pkg::SCALE_W-1:0]    scale_reg;
    logic                            neg_reg;
    logic [31:0]                     p1_reg;
    logic [61:0]                     p2_reg;
    logic [VW-1:0]                   res_reg;
    logic                            fin_reg;
    logic                            rovf_reg;

    logic                            in_acc;
    logic                            store_ok;
    logic                            cfg_wr;
    rmsn_pkg::unit_ctrl_t            u_ctrl;
    rmsn_pkg::unit_stat_t            u_stat;
    logic [rmsn_pkg::OPND_W-1:0]     u_opnd;
    logic [rmsn_pkg::DVSR_W-1:0]     u_dvsr;
    logic [rmsn_pkg::OPND_W-1:0]     u_res;
    logic [rmsn_pkg::DVSR_W-1:0]     v_calc;
    logic [2*VW-1:0]                 rd_data;
    logic [VW-1:0]                   mx;
    logic [VW-1:0]                   mw;
    logic [61:0]                     rsum;
    logic [31:0]                     mag;
    logic [VW-1:0]                   res_calc;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == ADDR_EPSILON_BIT) ? 32'(eps_reg) : 32'd0;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign store_ok = (count_reg < CW'(MAX_LEN));

    assign v_calc = u_res[rmsn_pkg::DVSR_W-1:0] + rmsn_pkg::DVSR_W'(eps_reg);

    rmsn_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (in_acc && store_ok),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({element_value, gain_weight}),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    rmsn_unit u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (u_ctrl),
        .operand (u_opnd),
        .divisor (u_dvsr),
        .stat    (u_stat),
        .result  (u_res)
    );

    always_comb
    begin
        u_ctrl.start   = 1'b0;
        u_ctrl.is_sqrt = 1'b0;
        u_ctrl.steps   = rmsn_pkg::MEAN_STEPS;
        u_opnd         = {sum_reg, {(rmsn_pkg::OPND_W - rmsn_pkg::SUM_W){1'b0}}};
        u_dvsr         = rmsn_pkg::DVSR_W'(count_reg);
        case (state_reg)
            S_MEAN:
            begin
                u_ctrl.start = 1'b1;
            end
            S_RECIP:
            begin
                u_ctrl.start = 1'b1;
                u_ctrl.steps = rmsn_pkg::RECIP_STEPS;
                u_opnd       = rmsn_pkg::OPND_W'(1) << (rmsn_pkg::OPND_W - 1);
                u_dvsr       = v_reg;
            end
            S_SQRT:
            begin
                u_ctrl.start   = 1'b1;
                u_ctrl.is_sqrt = 1'b1;
                u_ctrl.steps   = rmsn_pkg::SQRT_STEPS;
                u_opnd         = u_res;
            end
            default:
            begin
            end
        endcase
    end

    // magnitudes and rounding
    always_comb
    begin
        mx   = rd_data[2*VW-1] ? (VW'(0) - rd_data[2*VW-1:VW]) : rd_data[2*VW-1:VW];
        mw   = rd_data[VW-1] ? (VW'(0) - rd_data[VW-1:0]) : rd_data[VW-1:0];
        rsum = p2_reg + (62'd1 << 29);
        mag  = rsum[61:30];
        if (neg_reg)
        begin
            res_calc = (mag >= 32'd32768) ? 16'h8000 : (VW'(0) - mag[VW-1:0]);
        end
        else
        begin
            res_calc = (mag > 32'd32767) ? 16'h7FFF : mag[VW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_ACC;
                    if (store_ok)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_ACC:
            begin
                sum_next   = sum_reg + rmsn_pkg::SUM_W'(sq_reg);
                state_next = last_reg ? S_MEAN : S_IDLE;
            end
            S_MEAN:
            begin
                state_next = S_MEANW;
            end
            S_MEANW:
            begin
                if (u_stat.done)
                begin
                    k_next     = '0;
                    state_next = (v_calc == '0) ? S_RD : S_RECIP;
                end
            end
            S_RECIP:
            begin
                state_next = S_RECIPW;
            end
            S_RECIPW:
            begin
                if (u_stat.done)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                state_next = S_SQRTW;
            end
            S_SQRTW:
            begin
                if (u_stat.done)
                begin
                    k_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_RND;
            end
            S_RND:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (fin_reg)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eps_reg   <= rmsn_pkg::EPS_RESET;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            if (cfg_wr && (paddr[2] == ADDR_EPSILON_BIT))
            begin
                eps_reg <= pwdata[rmsn_pkg::EPS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            last_reg <= end_of_vector;
            sq_reg   <= store_ok ? rmsn_pkg::SQ_W'(element_value * element_value) : '0;
        end
        if ((state_reg == S_MEANW) && u_stat.done)
        begin
            v_reg     <= v_calc;
            scale_reg <= rmsn_pkg::SCALE_MAX;
        end
        if ((state_reg == S_SQRTW) && u_stat.done)
        begin
            scale_reg <= u_res[rmsn_pkg::SCALE_W-1:0];
        end
        if (state_reg == S_MUL1)
        begin
            p1_reg  <= 32'(mx) * 32'(mw);
            neg_reg <= rd_data[2*VW-1] ^ rd_data[VW-1];
        end
        if (state_reg == S_MUL2)
        begin
            p2_reg <= 62'(p1_reg[30:0]) * 62'(scale_reg);
        end
        if (state_reg == S_RND)
        begin
            res_reg  <= res_calc;
            fin_reg  <= (CW'(k_reg + 1'b1) == count_reg);
            rovf_reg <= ovf_reg;
        end
    end

    assign out_valid        = (state_reg == S_OUT);
    assign normalized_value = res_reg;
    assign final_output     = fin_reg;
    assign length_overflow  = rovf_reg;

    a_out_has_elements: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_reg != '0))
        else $error("result item with an empty vector");

    a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_output && !out_stall) |=> (!out_valid && !in_stall))
        else $error("block did not return to idle after the final result");

    a_overflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (count_reg == CW'(MAX_LEN))) |=> ovf_reg)
        else $error("dropped item did not raise the overflow flag");

endmodule

### verif/rms_normalizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_normalizer_top_test
// self-checking bench for the rms normalizer: vectors of random length and
// content are streamed in, a bit-exact predictor computes the normalized
// items of each vector, and a scoreboard compares every output item in order
// ----------------------------------------------------------------------------
module rms_normalizer_top_test;

    typedef struct packed {
        logic signed [15:0] value;
        logic               fin;
        logic               ovf;
    } norm_item_t;

    class norm_scoreboard;
        logic [15:0] vals[$];
        logic [15:0] gains[$];
        logic [36:0] sq_sum;
        logic        dropped;
        logic [23:0] eps;
        norm_item_t  pending[$];
        int          mismatches;

        function void clear_vector();
            vals.delete();
            gains.delete();
            sq_sum  = '0;
            dropped = 1'b0;
        endfunction

        function logic [63:0] inv_root(logic [63:0] v);
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] root;
            logic [63:0] bt;
            if (v == 0)
                return 64'd1 << 30;
            q    = (64'd1 << 60) / v;
            rem  = q;
            root = 0;
            for (int i = 30; i >= 0; i--)
            begin
                bt = 64'd1 << (2 * i);
                if (rem >= root + bt)
                begin
                    rem  = rem - (root + bt);
                    root = (root >> 1) + bt;
                end
                else
                    root = root >> 1;
            end
            return root;
        endfunction

        function logic [15:0] scale_elem(logic signed [15:0] x, logic [63:0] s,
                                         logic signed [15:0] w);
            logic        neg;
            logic [63:0] mx;
            logic [63:0] mw;
            logic [63:0] mag;
            neg = (x < 0) != (w < 0);
            mx  = x < 0 ? 64'(-32'(x)) : 64'(x);
            mw  = w < 0 ? 64'(-32'(w)) : 64'(w);
            mag = (mx * s * mw + (64'd1 << 29)) >> 30;
            if (neg)
                return mag >= 32768 ? 16'h8000 : 16'(17'h10000 - 17'(mag));
            return mag > 32767 ? 16'h7fff : 16'(mag);
        endfunction

        function void note_input(logic signed [15:0] x, logic signed [15:0] w,
                                 logic last);
            logic [63:0] v;
            logic [63:0] s;
            norm_item_t  it;
            int          n;
            if (vals.size() < rmsn_pkg::MAX_LEN_DEF)
            begin
                vals.push_back(x);
                gains.push_back(w);
                sq_sum = 37'(sq_sum + 37'(64'(32'(x) * 32'(x))));
            end
            else
                dropped = 1'b1;
            if (!last)
                return;
            n = vals.size();
            v = 64'(sq_sum) / n + 64'(eps);
            s = inv_root(v);
            for (int k = 0; k < n; k++)
            begin
                it.value = scale_elem(vals[k], s, gains[k]);
                it.fin   = (k == n - 1);
                it.ovf   = dropped;
                pending.push_back(it);
            end
            clear_vector();
        endfunction

        function void check_output(norm_item_t got);
            norm_item_t exp_it;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output item %h", got);
                return;
            end
            exp_it = pending.pop_front();
            if (exp_it !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp val=%0d fin=%b ovf=%b, got val=%0d fin=%b ovf=%b",
                             exp_it.value, exp_it.fin, exp_it.ovf,
                             got.value, got.fin, got.ovf);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic signed [15:0] element_value = '0;
    logic signed [15:0] gain_weight = '0;
    logic        end_of_vector = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic signed [15:0] normalized_value;
    logic        final_output;
    logic        length_overflow;

    norm_scoreboard sb = new();
    int  idle_cycles;
    bit  no_idle;
    bit  hold_off;
    int  hold_len;

    always #4 clk = ~clk;

    rms_normalizer_top u_top (.*);

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(element_value, gain_weight, end_of_vector);
        if (rst_n && out_valid && !out_stall)
            sb.check_output({normalized_value, final_output, length_overflow});
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall process
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (burst - 1) @(posedge clk);
                @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_eps(logic [23:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= rmsn_pkg::ADDR_EPSILON;
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.eps = val;
    endtask

    task automatic send_item(logic signed [15:0] x, logic signed [15:0] w, logic last);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= x;
        gain_weight   <= w;
        end_of_vector <= last;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic send_vector(int len, int kind);
        logic signed [15:0] x;
        logic signed [15:0] w;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0: x = 16'($urandom);
                1: x = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
                default: x = $signed(16'($urandom_range(0, 63))) - 16'sd32;
            endcase
            w = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                16'($urandom_range(3000, 5000));
            send_item(x, w, i == len - 1);
        end
    endtask

    initial
    begin
        sb.eps = rmsn_pkg::EPS_RESET;
        sb.clear_vector();
        idle_cycles = 0;
        no_idle = 0;
        hold_off = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, single element, all-zero vector, overflow
        send_item(16'sh7fff, 16'sh7fff, 0);
        send_item(-16'sh8000, 16'sh7fff, 0);
        send_item(16'sh0001, -16'sh8000, 0);
        send_item(16'sh0000, 16'sh1000, 1);
        send_item(16'sh1000, -16'sh8000, 1);
        send_item(16'sh0000, 16'sh1000, 0);
        send_item(16'sh0000, 16'sh7fff, 1);
        go_quiet();
        write_eps(24'd0);
        send_item(16'sh0000, 16'sh1000, 1);
        send_item(16'sh0001, 16'sh7fff, 0);
        send_item(-16'sh0001, 16'sh7fff, 1);
        go_quiet();
        write_eps(24'hffffff);
        send_item(16'sh5555, -16'sh5556, 0);
        send_item(-16'sh2aab, 16'sh2aaa, 1);
        go_quiet();
        write_eps(rmsn_pkg::EPS_RESET);
        send_vector(rmsn_pkg::MAX_LEN_DEF + 3, 1);

        // long receiver hold-off while the sender keeps going
        hold_len = 400;
        hold_off = 1;
        send_vector(12, 1);
        send_vector(8, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            go_quiet();
            write_eps(ph == 0 ? 24'd1 : 24'($urandom_range(0, 16777215)));
            for (int v = 0; v < 2; v++)
                send_vector($urandom_range(1, 5), $urandom_range(0, 2));
        end

        no_idle = 1;
        for (int v = 0; v < 4; v++)
            send_vector($urandom_range(1, 4), $urandom_range(0, 2));

        go_quiet();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
design/rmsn_pkg.sv
design/rmsn_mem.sv
design/rmsn_unit.sv
design/rms_normalizer_top.sv
verif/rms_normalizer_top_test.sv
